// ----- rtl/core/mxdq_pkg.sv -----
// Package with shared types, constants and the float32 packing function.
package mxdq_pkg;

   localparam int LaneCount = 2;

   typedef enum logic {
      OP_FP8 = 1'b0,
      OP_FP4 = 1'b1
   } op_type;

   // One lane's decoded element: sign, 4-bit magnitude, power of two.
   typedef struct packed {
      logic       neg;
      logic [3:0] mag;
      logic [9:0] pw;   // signed power relative to mag
      logic       zero; // forced zero (sign kept in neg)
   } elem_type;

   function automatic logic [2:0] fp4_mag2(input logic [2:0] code);
      logic [2:0] m;
      case (code)
         3'd0: m = 3'd0;
         3'd1: m = 3'd1;
         3'd2: m = 3'd2;
         3'd3: m = 3'd3;
         default: m = 3'd0;
      endcase
      return m;
   endfunction

   // Rounds (-1)^neg * mag * 2^pw into float32 bits.
   function automatic logic [31:0] pack_f32(input elem_type e);
      logic [31:0]       sbit;
      logic [1:0]        msb;
      logic signed [9:0] biased;
      logic signed [9:0] sh;
      logic [2:0]        r;
      logic [3:0]        q;
      logic [3:0]        rem;
      logic [3:0]        half;
      logic [31:0]       res;
      sbit = {e.neg, 31'd0};
      msb = e.mag[3] ? 2'd3 : e.mag[2] ? 2'd2 : e.mag[1] ? 2'd1 : 2'd0;
      biased = $signed(e.pw) + $signed({8'd0, msb}) + 10'sd127;
      sh = $signed(e.pw) + 10'sd149;
      r = 3'd0;
      q = 4'd0;
      rem = 4'd0;
      half = 4'd0;
      if (e.zero || e.mag == 4'd0) begin
         res = sbit;
      end else if (biased >= 10'sd255) begin
         res = sbit | 32'h7F80_0000;
      end else if (biased >= 10'sd1) begin
         res = sbit | {1'b0, biased[7:0], 23'd0}
               | ((32'(e.mag) << (5'd23 - 5'(msb))) & 32'h007F_FFFF);
      end else if (sh >= 10'sd0) begin
         res = sbit | (32'(e.mag) << sh[4:0]);
      end else if (sh < -10'sd4) begin
         // A shift of five or more always lands below half of the smallest subnormal.
         res = sbit;
      end else begin
         r = 3'(-sh);
         q = e.mag >> r;
         rem = e.mag & ((4'd1 << r) - 4'd1);
         half = 4'd1 << (r - 3'd1);
         if (rem > half || (rem == half && q[0])) begin
            q = q + 4'd1;
         end
         res = sbit | 32'(q);
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/mxdq_lane.sv -----
// One dequantizer lane: decodes an FP8 byte or FP4 nibble and packs float32.
module mxdq_lane (
   input  logic        fp8_mode,
   input  logic [7:0]  code,
   input  logic [7:0]  scale,
   output logic [31:0] value
);
   mxdq_pkg::elem_type e;
   logic [9:0]         sadj;

   always_comb begin
      sadj = {2'd0, scale} - 10'd127;
      e.zero = (scale == 8'hFF);
      if (fp8_mode) begin
         e.neg = code[7];
         if (code[6:0] == 7'h7F) begin
            e.neg = 1'b0;
            e.zero = 1'b1;
         end
         if (code[6:3] == 4'd0) begin
            e.mag = {1'b0, code[2:0]};
            e.pw = sadj - 10'd9;
         end else begin
            e.mag = {1'b1, code[2:0]};
            e.pw = sadj + {6'd0, code[6:3]} - 10'd10;
         end
      end else begin
         e.neg = code[3];
         case (code[2:0])
            3'd4: e.mag = 4'd4;
            3'd5: e.mag = 4'd6;
            3'd6: e.mag = 4'd8;
            3'd7: e.mag = 4'd12;
            default: e.mag = {1'b0, mxdq_pkg::fp4_mag2(code[2:0])};
         endcase
         e.pw = sadj - 10'd1;
      end
   end

   assign value = mxdq_pkg::pack_f32(e);
endmodule

// ----- rtl/core/mx_fp8_fp4_dequantizer.sv -----
// Top level: two decode lanes, an ordering merge and a skid-buffered output.
// Accepted request words are registered in the main or skid entry before leaving.
// Throughput: one word per cycle unless skid is full; lanes work in parallel on one byte.
// A two-entry output stage keeps req_tready high while one word waits.
// Reset (synchronous, active high) clears the valid flags and the order bit.
module mx_fp8_fp4_dequantizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // data_byte[7:0], scale_byte[15:8]
   input  logic        req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // first_value[31:0], second_value[63:32]
   output logic        rsp_tuser   // second_valid
);
   logic        order_ff, order_in;
   logic [31:0] lo_val, hi_val;
   logic        fp8;
   logic [64:0] word;
   logic [64:0] main_ff, main_in, skid_ff, skid_in;
   logic        mv_ff, mv_in, sv_ff, sv_in;
   logic        acc;

   assign fp8 = (req_tuser == mxdq_pkg::OP_FP8);

   mxdq_lane u_lane_lo (
      .fp8_mode(fp8), .code(fp8 ? req_tdata[7:0] : {4'd0, req_tdata[3:0]}),
      .scale(req_tdata[15:8]), .value(lo_val)
   );
   mxdq_lane u_lane_hi (
      .fp8_mode(1'b0), .code({4'd0, req_tdata[7:4]}),
      .scale(req_tdata[15:8]), .value(hi_val)
   );

   always_comb begin
      if (fp8) begin
         word = {1'b0, 32'd0, lo_val};
      end else if (order_ff) begin
         word = {1'b1, lo_val, hi_val};
      end else begin
         word = {1'b1, hi_val, lo_val};
      end
   end

   assign req_tready = !sv_ff;
   assign acc = req_tvalid && req_tready;
   assign order_in = csr_we ? csr_wdata : order_ff;

   always_comb begin
      main_in = main_ff;
      mv_in = mv_ff;
      skid_in = skid_ff;
      sv_in = sv_ff;
      if (!mv_ff || rsp_tready) begin
         if (sv_ff) begin
            main_in = skid_ff;
            mv_in = 1'b1;
            sv_in = 1'b0;
         end else begin
            main_in = word;
            mv_in = acc;
         end
      end else if (acc) begin
         skid_in = word;
         sv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
         mv_ff <= 1'b0;
         sv_ff <= 1'b0;
      end else begin
         order_ff <= order_in;
         mv_ff <= mv_in;
         sv_ff <= sv_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = mv_ff;
   assign rsp_tdata = main_ff[63:0];
   assign rsp_tuser = main_ff[64];
endmodule
